// ===== rtl/core/exact_colour_palette_builder_unit_macros.svh =====
// Assertion macros used by the palette builder datapath.
`ifndef EXACT_COLOUR_PALETTE_BUILDER_UNIT_MACROS_SVH
`define EXACT_COLOUR_PALETTE_BUILDER_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk_i outside reset.
`define ECPB_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("check failed: lbl");

// Next-cycle implication, checked on clk_i outside reset.
`define ECPB_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("check failed: lbl");

`endif

// ===== rtl/core/ecpb_pkg.sv =====
// Package with the command and status types between controller and datapath.
package ecpb_pkg;

  localparam int unsigned IndexWidth = 8;
  localparam int unsigned CountWidth = 9;
  localparam int unsigned ColourWidth = 16;

  localparam logic ModeBuild = 1'b0;
  localparam logic ModeLookup = 1'b1;

  typedef struct packed {
    logic load;
    logic scan;
    logic finish;
  } ecpb_cmd_t;

  typedef struct packed {
    logic hit;
    logic exhausted;
  } ecpb_status_t;

endpackage

// ===== rtl/core/exact_colour_palette_builder_unit.sv =====
// Top level of the exact-match colour palette builder.
// Usage:
//   Drive mode_i, clear_i and pixel_colour_i and raise start; the transfer is
//   taken at the rising edge where start is high and busy is low. busy stays
//   high while the palette is scanned.
//   mode_i = 0 builds: a colour already stored returns its index, a new colour
//   is appended while there is room, otherwise the sticky overflow is set.
//   clear_i in build mode empties the palette and overflow first.
//   mode_i = 1 looks the colour up and changes nothing.
// Scan: busy stays high while the single-port palette memory is read one
//   entry per cycle through a read register, until a hit or until all filled
//   entries have been compared. done_o is registered and follows in the cycle
//   after the last busy cycle.
//   busy is low again in the cycle done_o is high, so the next item can start.
// Results: colour_index_o, found_o, overflow_o, entry_count_o hold valid data
//   for the single cycle that done_o is high; the receiver cannot stall.
// Reset: the palette is empty and overflow is clear; memory contents are left
//   as they are and are never read before being written.
module exact_colour_palette_builder_unit #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start,
  output logic                             busy,
  input  logic                             mode_i,
  input  logic                             clear_i,
  input  logic [ecpb_pkg::ColourWidth-1:0] pixel_colour_i,
  output logic                             done_o,
  output logic [ecpb_pkg::IndexWidth-1:0]  colour_index_o,
  output logic                             found_o,
  output logic                             overflow_o,
  output logic [ecpb_pkg::CountWidth-1:0]  entry_count_o
);
  import ecpb_pkg::*;

  ecpb_cmd_t    cmd;
  ecpb_status_t status;

  ecpb_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  ecpb_datapath #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .mode_i         (mode_i),
    .clear_i        (clear_i),
    .pixel_colour_i (pixel_colour_i),
    .done_o         (done_o),
    .colour_index_o (colour_index_o),
    .found_o        (found_o),
    .overflow_o     (overflow_o),
    .entry_count_o  (entry_count_o)
  );

endmodule

// ===== rtl/core/ecpb_ctrl.sv =====
// Controller state machine: accept a transfer, scan the palette, finish.
module ecpb_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  ecpb_pkg::ecpb_status_t status_i,
  output ecpb_pkg::ecpb_cmd_t    cmd_o
);
  import ecpb_pkg::*;

  typedef enum logic [1:0] {
    StIdle = 2'b01,
    StScan = 2'b10
  } state_e;

  state_e state_q, state_d;
  logic   done_scan;

  assign done_scan = status_i.hit | status_i.exhausted;

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    unique case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = StScan;
        end
      end
      StScan: begin
        cmd_o.scan = 1'b1;
        if (done_scan) begin
          cmd_o.finish = 1'b1;
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != StIdle);

endmodule

// ===== rtl/core/ecpb_datapath.sv =====
// Datapath: palette memory, fill count, overflow flag, scan pipeline, result registers.
module ecpb_datapath #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ecpb_pkg::ecpb_cmd_t                  cmd_i,
  output ecpb_pkg::ecpb_status_t               status_o,
  input  logic                                mode_i,
  input  logic                                clear_i,
  input  logic [ecpb_pkg::ColourWidth-1:0]    pixel_colour_i,
  output logic                                done_o,
  output logic [ecpb_pkg::IndexWidth-1:0]     colour_index_o,
  output logic                                found_o,
  output logic                                overflow_o,
  output logic [ecpb_pkg::CountWidth-1:0]     entry_count_o
);
  import ecpb_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);
  localparam int unsigned CW = $clog2(PALETTE_ENTRIES + 1);
  localparam logic [CW-1:0] Entries = CW'(PALETTE_ENTRIES);

  logic [ColourWidth-1:0] mem [PALETTE_ENTRIES];

  logic [ColourWidth-1:0] colour_q;
  logic                   mode_q;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic                   full_q, full_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [ColourWidth-1:0] rd_data_q;
  logic                   cmp_vld_q;
  logic [AW-1:0]          cmp_idx_q;
  logic                   issue;
  logic                   hit;
  logic                   wr_en;
  logic [CW-1:0]          res_idx;
  logic                   res_found;
  logic [31:0]            res_idx_ext;
  logic [31:0]            cnt_ext;
  logic                   done_q;
  logic [IndexWidth-1:0]  index_q;
  logic                   found_q;
  logic                   ovf_q;
  logic [CountWidth-1:0]  count_q;

  assign hit = cmp_vld_q && (rd_data_q == colour_q);
  assign status_o.hit = hit;
  assign status_o.exhausted = !cmp_vld_q && (idx_q >= cnt_q);
  assign issue = cmd_i.scan && (idx_q < cnt_q);

  always_comb begin
    cnt_d = cnt_q;
    full_d = full_q;
    idx_d = idx_q;
    wr_en = 1'b0;
    res_idx = '0;
    res_found = 1'b0;
    if (cmd_i.load) begin
      idx_d = '0;
      if (mode_i == ModeBuild && clear_i) begin
        cnt_d = '0;
        full_d = 1'b0;
      end
    end else if (issue) begin
      idx_d = idx_q + 1'b1;
    end
    if (cmd_i.finish) begin
      priority if (hit) begin
        res_idx = CW'(cmp_idx_q);
        res_found = 1'b1;
      end else if (mode_q == ModeBuild && cnt_q < Entries) begin
        wr_en = 1'b1;
        res_idx = cnt_q;
        res_found = 1'b1;
        cnt_d = cnt_q + 1'b1;
      end else if (mode_q == ModeBuild) begin
        full_d = 1'b1;
      end else begin
        res_found = 1'b0;
      end
    end
  end

  assign res_idx_ext = 32'(res_idx);
  assign cnt_ext = 32'(cnt_d);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[cnt_q[AW-1:0]] <= colour_q;
    end
    if (issue) begin
      rd_data_q <= mem[idx_q[AW-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      colour_q <= pixel_colour_i;
      mode_q <= mode_i;
    end
    if (issue) begin
      cmp_idx_q <= idx_q[AW-1:0];
    end
    if (cmd_i.finish) begin
      index_q <= res_idx_ext[IndexWidth-1:0];
      found_q <= res_found;
      ovf_q <= full_d;
      count_q <= cnt_ext[CountWidth-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      full_q <= 1'b0;
      idx_q <= '0;
      cmp_vld_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      full_q <= full_d;
      idx_q <= idx_d;
      cmp_vld_q <= issue && !cmd_i.load;
      done_q <= cmd_i.finish;
    end
  end

  assign done_o = done_q;
  assign colour_index_o = index_q;
  assign found_o = found_q;
  assign overflow_o = ovf_q;
  assign entry_count_o = count_q;

`include "exact_colour_palette_builder_unit_macros.svh"

  `ECPB_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= Entries)
  `ECPB_ASSERT_NEXT(a_wr_bumps_cnt, wr_en, cnt_q == $past(cnt_q) + 1'b1)
  `ECPB_ASSERT_NOW(a_hit_in_range, hit, CW'(cmp_idx_q) < cnt_q)
  `ECPB_ASSERT_NOW(a_full_only_when_filled, $rose(full_q), cnt_q == Entries)

endmodule
